### rtl/apam_pkg.sv
package apam_pkg;

    // fixed image format
    localparam logic [14:0] IMG_DIM         = 15'd4096;
    localparam logic [2:0]  BYTES_PER_PIXEL = 3'd3;

    // Q16.16 one
    localparam logic signed [32:0] Q_ONE = 33'sd65536;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_COEF_A     = 3'd1,
        CFG_COEF_B     = 3'd2,
        CFG_OFFSET_ROW = 3'd3,
        CFG_OFFSET_COL = 3'd4,
        CFG_SRC_HEIGHT = 3'd5,
        CFG_SRC_WIDTH  = 3'd6,
        CFG_DST_LINE   = 3'd7
    } cfg_index_e;

    // transform modes
    typedef enum logic [2:0] {
        MODE_TRANSLATE  = 3'd0,
        MODE_ROTATE_FWD = 3'd1,
        MODE_MIRROR     = 3'd2,
        MODE_SHEAR      = 3'd3,
        MODE_ROTATE_INV = 3'd4,
        MODE_SCALE_INV  = 3'd5
    } mode_e;

    // one input coordinate
    typedef struct packed {
        logic [12:0] pix_row;
        logic [12:0] pix_col;
    } pixel_t;

    // one mapped result
    typedef struct packed {
        logic [27:0] src_address;
        logic [27:0] dst_address;
        logic        in_range;
    } result_t;

endpackage

### rtl/affine_pixel_address_mapper_unit.sv
// Affine pixel address mapper.
// Input transfer: pixel (row, col) is taken at a rising edge with start high and busy low.
// busy stays low, so a raster counter may present a new coordinate every cycle.
// Result transfer: done is high for exactly one cycle with result valid in that cycle;
// the receiver cannot stall, it must take every result as it comes.
// done and the result come from the output register, after the operand, product, sum,
// clamp and address registers; one result per cycle.
// Pipeline: operand select, four 16x33 multipliers, sum and truncate toward zero,
// bounds checks and coordinate clamps, address multiply-add, overflow check and output.
// The sustained rate of one pixel per clock is set by the fully pipelined multipliers.
// Configuration: cfg_we writes register cfg_index with cfg_data at once; write only while
// no pixel is in flight. Registers: mode, coef_a, coef_b (Q16.16), offset_row,
// offset_col, src_height, src_width, dst_line_bytes.
// Reset (rst_n low, asynchronous) empties the pipeline and sets mode 0, coefficients
// and offsets 0, source size 1x1 and a destination line of 4 bytes.
// in_range low means skip the copy; both addresses are then zero.
module affine_pixel_address_mapper_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  apam_pkg::pixel_t    pixel,
    output logic                done,
    output apam_pkg::result_t   result,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // configuration registers
    logic [2:0]         mode_reg;
    logic signed [31:0] coef_a_reg;
    logic signed [31:0] coef_b_reg;
    logic signed [14:0] offset_row_reg;
    logic signed [14:0] offset_col_reg;
    logic [12:0]        src_height_reg;
    logic [12:0]        src_width_reg;
    logic [15:0]        dst_line_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= apam_pkg::MODE_TRANSLATE;
            coef_a_reg     <= '0;
            coef_b_reg     <= '0;
            offset_row_reg <= '0;
            offset_col_reg <= '0;
            src_height_reg <= 13'd1;
            src_width_reg  <= 13'd1;
            dst_line_reg   <= 16'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apam_pkg::CFG_MODE:       mode_reg       <= cfg_data[2:0];
                apam_pkg::CFG_COEF_A:     coef_a_reg     <= cfg_data;
                apam_pkg::CFG_COEF_B:     coef_b_reg     <= cfg_data;
                apam_pkg::CFG_OFFSET_ROW: offset_row_reg <= cfg_data[14:0];
                apam_pkg::CFG_OFFSET_COL: offset_col_reg <= cfg_data[14:0];
                apam_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[12:0];
                apam_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[12:0];
                apam_pkg::CFG_DST_LINE:   dst_line_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline never holds off an input transfer
    assign busy = 1'b0;

    // ---------------- stage 1: operand select ----------------
    logic signed [15:0] r16;
    logic signed [15:0] c16;
    logic signed [15:0] rr16;
    logic signed [15:0] cc16;
    logic signed [32:0] a33;
    logic signed [32:0] b33;
    logic signed [32:0] nb33;
    logic signed [32:0] as33;
    logic signed [32:0] bs33;

    logic signed [15:0] u1_next, u2_next, u3_next, u4_next;
    logic signed [32:0] v1_next, v2_next, v3_next, v4_next;
    logic signed [15:0] u1_reg, u2_reg, u3_reg, u4_reg;
    logic signed [32:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic [12:0]        s1_row_reg, s1_col_reg;
    logic               s1_valid_reg;

    assign r16  = {3'b000, pixel.pix_row};
    assign c16  = {3'b000, pixel.pix_col};
    assign rr16 = r16 + {offset_row_reg[14], offset_row_reg};
    assign cc16 = c16 + {offset_col_reg[14], offset_col_reg};
    assign a33  = {coef_a_reg[31], coef_a_reg};
    assign b33  = {coef_b_reg[31], coef_b_reg};
    assign nb33 = -b33;
    // nonpositive scale counts as one
    assign as33 = (coef_a_reg[31] || (coef_a_reg == '0)) ? apam_pkg::Q_ONE : a33;
    assign bs33 = (coef_b_reg[31] || (coef_b_reg == '0)) ? apam_pkg::Q_ONE : b33;

    // row = u1*v1 + u2*v2, col = u3*v3 + u4*v4
    always_comb
    begin
        u1_next = '0; v1_next = '0; u2_next = '0; v2_next = '0;
        u3_next = '0; v3_next = '0; u4_next = '0; v4_next = '0;
        unique case (mode_reg)
            apam_pkg::MODE_TRANSLATE:
            begin
                u1_next = r16;   v1_next = apam_pkg::Q_ONE;
                u2_next = 16'sd1; v2_next = a33;
                u3_next = c16;   v3_next = apam_pkg::Q_ONE;
                u4_next = 16'sd1; v4_next = b33;
            end
            apam_pkg::MODE_ROTATE_FWD:
            begin
                u1_next = r16; v1_next = a33;
                u2_next = c16; v2_next = nb33;
                u3_next = r16; v3_next = b33;
                u4_next = c16; v4_next = a33;
            end
            apam_pkg::MODE_MIRROR:
            begin
                u1_next = r16; v1_next = a33;
                u3_next = c16; v3_next = b33;
            end
            apam_pkg::MODE_SHEAR:
            begin
                u1_next = r16; v1_next = apam_pkg::Q_ONE;
                u2_next = c16; v2_next = a33;
                u3_next = r16; v3_next = b33;
                u4_next = c16; v4_next = apam_pkg::Q_ONE;
            end
            apam_pkg::MODE_ROTATE_INV:
            begin
                u1_next = rr16; v1_next = a33;
                u2_next = cc16; v2_next = b33;
                u3_next = cc16; v3_next = a33;
                u4_next = rr16; v4_next = nb33;
            end
            apam_pkg::MODE_SCALE_INV:
            begin
                u1_next = r16; v1_next = as33;
                u3_next = c16; v3_next = bs33;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        u1_reg     <= u1_next;
        u2_reg     <= u2_next;
        u3_reg     <= u3_next;
        u4_reg     <= u4_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        v3_reg     <= v3_next;
        v4_reg     <= v4_next;
        s1_row_reg <= pixel.pix_row;
        s1_col_reg <= pixel.pix_col;
    end

    // ---------------- stage 2: products ----------------
    logic signed [48:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [12:0]        s2_row_reg, s2_col_reg;
    logic               s2_valid_reg;

    always_ff @(posedge clk)
    begin
        p1_reg     <= u1_reg * v1_reg;
        p2_reg     <= u2_reg * v2_reg;
        p3_reg     <= u3_reg * v3_reg;
        p4_reg     <= u4_reg * v4_reg;
        s2_row_reg <= s1_row_reg;
        s2_col_reg <= s1_col_reg;
    end

    // ---------------- stage 3: sum and truncate toward zero ----------------
    function automatic logic [33:0] trunc_q(input logic [49:0] v);
        logic [33:0] q;
        q = v[49:16];
        if (v[49] && (v[15:0] != '0))
            q = q + 34'd1;
        return q;
    endfunction

    logic [49:0] sum_row;
    logic [49:0] sum_col;
    logic [33:0] mr_reg, mc_reg;
    logic [12:0] s3_row_reg, s3_col_reg;
    logic        s3_valid_reg;

    assign sum_row = {p1_reg[48], p1_reg} + {p2_reg[48], p2_reg};
    assign sum_col = {p3_reg[48], p3_reg} + {p4_reg[48], p4_reg};

    always_ff @(posedge clk)
    begin
        mr_reg     <= trunc_q(sum_row);
        mc_reg     <= trunc_q(sum_col);
        s3_row_reg <= s2_row_reg;
        s3_col_reg <= s2_col_reg;
    end

    // ---------------- stage 4: bounds checks and clamps ----------------
    // nonnegative coordinate clamped so that any value past the address range stays past it
    function automatic logic [28:0] clamp29(input logic [34:0] d);
        logic [28:0] q;
        q = {1'b0, d[27:0]};
        if (d[33:28] != '0)
            q = 29'h1000_0000;
        return q;
    endfunction

    logic [14:0] h15, w15, hh, ww;
    logic [34:0] dr, dc;
    logic        fwd_src_ok, inv_src_ok;
    logic [12:0] sr_next, sc_next;
    logic [28:0] drow_next, dcol_next;
    logic        ok4_next;
    logic [12:0] sr_reg, sc_reg;
    logic [28:0] drow_reg, dcol_reg;
    logic        ok4_reg;
    logic        s4_valid_reg;

    assign h15 = {2'b00, src_height_reg};
    assign w15 = {2'b00, src_width_reg};
    assign hh  = (h15 > apam_pkg::IMG_DIM) ? apam_pkg::IMG_DIM : h15;
    assign ww  = (w15 > apam_pkg::IMG_DIM) ? apam_pkg::IMG_DIM : w15;

    assign dr = {mr_reg[33], mr_reg} - {{20{offset_row_reg[14]}}, offset_row_reg};
    assign dc = {mc_reg[33], mc_reg} - {{20{offset_col_reg[14]}}, offset_col_reg};

    assign fwd_src_ok = ({2'b00, s3_row_reg} < hh) && ({2'b00, s3_col_reg} < ww);
    assign inv_src_ok = !mr_reg[33] && (mr_reg[32:13] == '0)
                     && ({2'b00, mr_reg[12:0]} < hh)
                     && !mc_reg[33] && (mc_reg[32:13] == '0)
                     && ({2'b00, mc_reg[12:0]} < ww);

    always_comb
    begin
        sr_next   = s3_row_reg;
        sc_next   = s3_col_reg;
        drow_next = {16'b0, s3_row_reg};
        dcol_next = {16'b0, s3_col_reg};
        ok4_next  = 1'b0;
        unique case (mode_reg)
            apam_pkg::MODE_TRANSLATE, apam_pkg::MODE_ROTATE_FWD,
            apam_pkg::MODE_MIRROR, apam_pkg::MODE_SHEAR:
            begin
                drow_next = clamp29(dr);
                dcol_next = clamp29(dc);
                ok4_next  = fwd_src_ok && !dr[34] && !dc[34];
            end
            apam_pkg::MODE_ROTATE_INV, apam_pkg::MODE_SCALE_INV:
            begin
                sr_next  = mr_reg[12:0];
                sc_next  = mc_reg[12:0];
                ok4_next = inv_src_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sr_reg   <= sr_next;
        sc_reg   <= sc_next;
        drow_reg <= drow_next;
        dcol_reg <= dcol_next;
        ok4_reg  <= ok4_next;
    end

    // ---------------- stage 5: address multiply-add ----------------
    logic [15:0] src_line_raw;
    logic [15:0] src_line;
    logic [30:0] sa_full_reg;
    logic [45:0] da_full_reg;
    logic        ok5_reg;
    logic        s5_valid_reg;

    // source stride rounded up to a multiple of four bytes
    assign src_line_raw = 16'(src_width_reg) * 16'(apam_pkg::BYTES_PER_PIXEL) + 16'd3;
    assign src_line     = {src_line_raw[15:2], 2'b00};

    always_ff @(posedge clk)
    begin
        sa_full_reg <= 31'(sr_reg) * 31'(src_line)
                     + 31'(sc_reg) * 31'(apam_pkg::BYTES_PER_PIXEL);
        da_full_reg <= 46'(drow_reg) * 46'(dst_line_reg)
                     + 46'(dcol_reg) * 46'(apam_pkg::BYTES_PER_PIXEL);
        ok5_reg     <= ok4_reg;
    end

    // ---------------- stage 6: overflow check and output ----------------
    logic              ok6;
    apam_pkg::result_t result_next;
    apam_pkg::result_t result_reg;
    logic              done_reg;

    assign ok6 = ok5_reg && (sa_full_reg[30:28] == '0) && (da_full_reg[45:28] == '0);

    always_comb
    begin
        result_next.in_range    = ok6;
        result_next.src_address = ok6 ? sa_full_reg[27:0] : '0;
        result_next.dst_address = ok6 ? da_full_reg[27:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            done_reg     <= s5_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // every accepted pixel gives one result after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##6 done)
        else $error("result missing six cycles after input transfer");

    // a rejected pixel carries zero addresses
    a_zero_on_skip: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.in_range |-> result.src_address == '0 && result.dst_address == '0)
        else $error("addresses not cleared on out-of-range result");

    // a failed bounds check is never turned into a valid result
    a_bounds_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && !ok5_reg |=> done && !result.in_range)
        else $error("out-of-bounds pixel reported in range");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // mapping constants
    localparam longint QONE = 64'sd65536;
    localparam longint DIM = 64'sd4096;
    localparam longint BPP = 64'sd3;
    localparam longint ADDR_SPAN = 64'sd268435456;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ITEMS_PER_SETTING = 31;
    localparam int SETTINGS_PER_PHASE = 4;

    // mode codes with no package member
    localparam logic [2:0] MODE_UNUSED6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED7 = 3'd7;

    // directed table rows
    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        apam_pkg::cfg_index_e idx;
        logic [31:0]          data;
        apam_pkg::pixel_t     pix;
        logic                 typed;
        apam_pkg::result_t    want;
    } stim_row_t;

    localparam apam_pkg::result_t SKIP = '0;
    localparam apam_pkg::result_t ORIGIN_OK = apam_pkg::result_t'(57'd1);

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    apam_pkg::pixel_t  pixel;
    logic              done;
    apam_pkg::result_t result;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    // mirror of the block's registers
    logic [2:0]         m_mode;
    logic signed [31:0] m_coef_a;
    logic signed [31:0] m_coef_b;
    logic signed [14:0] m_off_row;
    logic signed [14:0] m_off_col;
    logic [12:0]        m_height;
    logic [12:0]        m_width;
    logic [15:0]        m_dst_line;

    apam_pkg::result_t pending_maps[$];
    apam_pkg::result_t want;
    logic              typed_on;
    apam_pkg::result_t typed_res;
    stim_row_t         dir_tab[$];

    int map_errors = 0;
    int n_in = 0;
    int n_out = 0;
    int n_valid = 0;
    int n_writes = 0;
    int cycles = 0;
    int pix_rmax = 0;
    int pix_cmax = 0;

    affine_pixel_address_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // expected addresses for one coordinate under the mirrored registers
    function automatic apam_pkg::result_t map_pixel(apam_pkg::pixel_t p);
        longint r, c, a, b, rr, cc, mr, mc, dr, dc;
        longint sa, da, h, w, line, dl, orow, ocol;
        logic ok;
        apam_pkg::result_t res;
        r = longint'(p.pix_row);
        c = longint'(p.pix_col);
        a = longint'(m_coef_a);
        b = longint'(m_coef_b);
        orow = longint'(m_off_row);
        ocol = longint'(m_off_col);
        dl = longint'(m_dst_line);
        h = longint'(m_height);
        w = longint'(m_width);
        line = (w * 3 + 3) / 4 * 4;
        if (h > DIM)
            h = DIM;
        if (w > DIM)
            w = DIM;
        ok = 1'b1;
        mr = 0;
        mc = 0;
        sa = 0;
        da = 0;
        case (m_mode)
            apam_pkg::MODE_TRANSLATE:
            begin
                mr = r * QONE + a;
                mc = c * QONE + b;
            end
            apam_pkg::MODE_ROTATE_FWD:
            begin
                mr = r * a - c * b;
                mc = r * b + c * a;
            end
            apam_pkg::MODE_MIRROR:
            begin
                mr = r * a;
                mc = c * b;
            end
            apam_pkg::MODE_SHEAR:
            begin
                mr = r * QONE + c * a;
                mc = r * b + c * QONE;
            end
            apam_pkg::MODE_ROTATE_INV:
            begin
                rr = r + orow;
                cc = c + ocol;
                mr = rr * a + cc * b;
                mc = cc * a - rr * b;
            end
            apam_pkg::MODE_SCALE_INV:
            begin
                // nonpositive scale counts as one
                if (a <= 0)
                    a = QONE;
                if (b <= 0)
                    b = QONE;
                mr = r * a;
                mc = c * b;
            end
            default:
                ok = 1'b0;
        endcase
        // truncate toward zero
        mr = mr / QONE;
        mc = mc / QONE;
        if (ok && m_mode <= apam_pkg::MODE_SHEAR)
        begin
            dr = mr - orow;
            dc = mc - ocol;
            ok = (r < h) && (c < w) && (dr >= 0) && (dc >= 0);
            sa = r * line + c * BPP;
            da = dr * dl + dc * BPP;
        end
        else if (ok)
        begin
            ok = (mr >= 0) && (mc >= 0) && (mr < h) && (mc < w);
            sa = mr * line + mc * BPP;
            da = r * dl + c * BPP;
        end
        if (ok && (sa < 0 || sa >= ADDR_SPAN || da < 0 || da >= ADDR_SPAN))
            ok = 1'b0;
        if (!ok)
        begin
            sa = 0;
            da = 0;
        end
        res.src_address = sa[27:0];
        res.dst_address = da[27:0];
        res.in_range = ok;
        return res;
    endfunction

    // result check, expectation on input transfer, register mirror
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_mode <= apam_pkg::MODE_TRANSLATE;
            m_coef_a <= '0;
            m_coef_b <= '0;
            m_off_row <= '0;
            m_off_col <= '0;
            m_height <= 13'd1;
            m_width <= 13'd1;
            m_dst_line <= 16'd4;
        end
        else
        begin
            if (done)
            begin
                n_out++;
                n_valid += int'(result.in_range);
                if (pending_maps.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %h", $time, result);
                    map_errors++;
                end
                else
                begin
                    want = pending_maps.pop_front();
                    if (result.src_address !== want.src_address)
                    begin
                        $display("%0t: src_address expected %h got %h",
                                 $time, want.src_address, result.src_address);
                        map_errors++;
                    end
                    if (result.dst_address !== want.dst_address)
                    begin
                        $display("%0t: dst_address expected %h got %h",
                                 $time, want.dst_address, result.dst_address);
                        map_errors++;
                    end
                    if (result.in_range !== want.in_range)
                    begin
                        $display("%0t: in_range expected %b got %b",
                                 $time, want.in_range, result.in_range);
                        map_errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                n_in++;
                pending_maps.insert(pending_maps.size(),
                                    typed_on ? typed_res : map_pixel(pixel));
            end
            if (cfg_we)
            begin
                n_writes++;
                case (cfg_index)
                    apam_pkg::CFG_MODE:       m_mode <= cfg_data[2:0];
                    apam_pkg::CFG_COEF_A:     m_coef_a <= cfg_data;
                    apam_pkg::CFG_COEF_B:     m_coef_b <= cfg_data;
                    apam_pkg::CFG_OFFSET_ROW: m_off_row <= cfg_data[14:0];
                    apam_pkg::CFG_OFFSET_COL: m_off_col <= cfg_data[14:0];
                    apam_pkg::CFG_SRC_HEIGHT: m_height <= cfg_data[12:0];
                    apam_pkg::CFG_SRC_WIDTH:  m_width <= cfg_data[12:0];
                    apam_pkg::CFG_DST_LINE:   m_dst_line <= cfg_data[15:0];
                    default:                  ;
                endcase
            end
        end
    end

    // one coordinate transfer, after an optional idle gap
    task automatic drive_pixel(apam_pkg::pixel_t p, int gap, logic typed,
                               apam_pkg::result_t res);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        pixel = p;
        typed_on = typed;
        typed_res = res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(apam_pkg::cfg_index_e idx, logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // append one row to the directed table
    task automatic add_row(stim_row_t t);
        dir_tab.insert(dir_tab.size(), t);
    endtask

    function automatic stim_row_t cfg_row(apam_pkg::cfg_index_e idx, logic [31:0] data);
        stim_row_t t;
        t = '{ROW_CFG, idx, data, '0, 1'b0, '0};
        return t;
    endfunction

    function automatic stim_row_t coord_row(int r, int c);
        stim_row_t t;
        t = '{ROW_PIX, apam_pkg::CFG_MODE, '0, '0, 1'b0, '0};
        t.pix.pix_row = r[12:0];
        t.pix.pix_col = c[12:0];
        return t;
    endfunction

    function automatic stim_row_t typed_row(int r, int c, apam_pkg::result_t res);
        stim_row_t t;
        t = coord_row(r, c);
        t.typed = 1'b1;
        t.want = res;
        return t;
    endfunction

    // idle cycles before a transfer, each cycle idle with the given percentage
    function automatic int pick_gap(int pct);
        int g;
        g = 0;
        while ($urandom_range(0, 99) < pct)
            g++;
        return g;
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(1, 8191);
        return $urandom_range(1, 64);
    endfunction

    function automatic int pick_offset();
        if ($urandom_range(0, 7) == 0)
            return int'($urandom_range(0, 32767)) - 16384;
        return -int'($urandom_range(0, 96));
    endfunction

    function automatic apam_pkg::pixel_t rand_pixel();
        apam_pkg::pixel_t p;
        if ($urandom_range(0, 7) == 0)
        begin
            p.pix_row = 13'($urandom_range(0, 8191));
            p.pix_col = 13'($urandom_range(0, 8191));
        end
        else
        begin
            p.pix_row = 13'($urandom_range(0, pix_rmax));
            p.pix_col = 13'($urandom_range(0, pix_cmax));
        end
        return p;
    endfunction

    // random register setting, coefficients shaped to the mode
    task automatic pick_setting();
        logic [2:0] md;
        int a, b, h, w, dl;
        if ($urandom_range(0, 15) == 0)
            md = 3'($urandom_range(MODE_UNUSED6, MODE_UNUSED7));
        else
            md = 3'($urandom_range(apam_pkg::MODE_TRANSLATE, apam_pkg::MODE_SCALE_INV));
        h = pick_size();
        w = pick_size();
        if ($urandom_range(0, 7) == 0)
            dl = 4 * int'($urandom_range(1, 8192));
        else
            dl = 4 * int'($urandom_range(1, 256));
        case (md)
            apam_pkg::MODE_TRANSLATE:
            begin
                a = int'($urandom_range(0, 4194304)) - 2097152;
                b = int'($urandom_range(0, 4194304)) - 2097152;
            end
            apam_pkg::MODE_ROTATE_FWD, apam_pkg::MODE_ROTATE_INV:
            begin
                a = int'($urandom_range(0, 131072)) - 65536;
                b = int'($urandom_range(0, 131072)) - 65536;
            end
            apam_pkg::MODE_MIRROR:
            begin
                a = $urandom_range(0, 1) ? 65536 : -65536;
                b = $urandom_range(0, 1) ? 65536 : -65536;
            end
            apam_pkg::MODE_SHEAR:
            begin
                a = int'($urandom_range(0, 65536)) - 32768;
                b = int'($urandom_range(0, 65536)) - 32768;
            end
            apam_pkg::MODE_SCALE_INV:
            begin
                a = int'($urandom_range(0, 262144)) - 16384;
                b = int'($urandom_range(0, 262144)) - 16384;
            end
            default:
            begin
                a = $urandom;
                b = $urandom;
            end
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            a = $urandom;
            b = $urandom;
        end
        pix_rmax = (h + 8 > 8191) ? 8191 : h + 8;
        pix_cmax = (w + 8 > 8191) ? 8191 : w + 8;
        write_reg(apam_pkg::CFG_MODE, 32'(md));
        write_reg(apam_pkg::CFG_COEF_A, a);
        write_reg(apam_pkg::CFG_COEF_B, b);
        write_reg(apam_pkg::CFG_OFFSET_ROW, pick_offset());
        write_reg(apam_pkg::CFG_OFFSET_COL, pick_offset());
        write_reg(apam_pkg::CFG_SRC_HEIGHT, h);
        write_reg(apam_pkg::CFG_SRC_WIDTH, w);
        write_reg(apam_pkg::CFG_DST_LINE, dl);
    endtask

    // main sequence
    initial
    begin
        int i, ph, s, k;
        int idle_pct[3];
        start = 1'b0;
        pixel = '0;
        cfg_we = 1'b0;
        cfg_index = apam_pkg::CFG_MODE;
        cfg_data = '0;
        typed_on = 1'b0;
        typed_res = '0;
        rst_n = 1'b0;
        idle_pct = '{22, 67, 0};

        // values after reset: 1x1 source, translate by zero
        add_row(typed_row(0, 0, ORIGIN_OK));
        add_row(typed_row(0, 1, SKIP));
        add_row(typed_row(1, 0, SKIP));
        add_row(typed_row(8191, 8191, SKIP));
        // oversized source clamps the bounds to the image limit
        add_row(cfg_row(apam_pkg::CFG_SRC_HEIGHT, 32'd8191));
        add_row(cfg_row(apam_pkg::CFG_SRC_WIDTH, 32'd8191));
        add_row(cfg_row(apam_pkg::CFG_DST_LINE, 32'd32768));
        add_row(coord_row(4095, 4095));
        add_row(typed_row(4096, 0, SKIP));
        add_row(typed_row(0, 4096, SKIP));
        // destination lands exactly on the address limit
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h1FFF_0000));
        add_row(typed_row(1, 0, SKIP));
        add_row(coord_row(0, 0));
        // shift below the box minimum
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'hFFFF_0000));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h0000_8000));
        add_row(typed_row(0, 0, SKIP));
        add_row(coord_row(5, 7));
        // forward rotation with offsets at both extremes
        add_row(cfg_row(apam_pkg::CFG_MODE, apam_pkg::MODE_ROTATE_FWD));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h0000_B505));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h0000_B505));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_ROW, 32'hFFFF_C000));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_COL, 32'h0000_3FFF));
        add_row(coord_row(100, 3));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_ROW, 32'h0000_3FFF));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_COL, 32'hFFFF_C000));
        add_row(coord_row(100, 3));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_ROW, 32'hFFFF_FF38));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_COL, 32'h0000_0000));
        add_row(coord_row(50, 60));
        // mirror with the most negative column factor
        add_row(cfg_row(apam_pkg::CFG_MODE, apam_pkg::MODE_MIRROR));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'hFFFF_0000));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h8000_0000));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_ROW, 32'hFFFF_C000));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_COL, 32'hFFFF_C000));
        add_row(coord_row(10, 0));
        add_row(coord_row(10, 1));
        // shear with the largest row factor
        add_row(cfg_row(apam_pkg::CFG_MODE, apam_pkg::MODE_SHEAR));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h7FFF_FFFF));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h0000_4000));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_ROW, 32'h0000_0000));
        add_row(cfg_row(apam_pkg::CFG_OFFSET_COL, 32'h0000_0000));
        add_row(coord_row(0, 1));
        add_row(coord_row(5, 0));
        // inverse rotation by zero angle
        add_row(cfg_row(apam_pkg::CFG_MODE, apam_pkg::MODE_ROTATE_INV));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h0001_0000));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h0000_0000));
        add_row(coord_row(12, 34));
        add_row(coord_row(8191, 0));
        // scale: nonpositive factors count as one, then a real scale
        add_row(cfg_row(apam_pkg::CFG_MODE, apam_pkg::MODE_SCALE_INV));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h0000_0000));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h8000_0000));
        add_row(coord_row(4095, 4095));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h0000_8000));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h0002_0000));
        add_row(coord_row(8191, 2000));
        add_row(coord_row(100, 2047));
        add_row(typed_row(100, 2048, SKIP));
        // unused mode codes
        add_row(cfg_row(apam_pkg::CFG_MODE, MODE_UNUSED6));
        add_row(typed_row(0, 0, SKIP));
        add_row(cfg_row(apam_pkg::CFG_MODE, MODE_UNUSED7));
        add_row(typed_row(0, 0, SKIP));
        // back to the smallest sizes
        add_row(cfg_row(apam_pkg::CFG_MODE, apam_pkg::MODE_TRANSLATE));
        add_row(cfg_row(apam_pkg::CFG_COEF_A, 32'h0000_0000));
        add_row(cfg_row(apam_pkg::CFG_COEF_B, 32'h0000_0000));
        add_row(cfg_row(apam_pkg::CFG_SRC_HEIGHT, 32'd1));
        add_row(cfg_row(apam_pkg::CFG_SRC_WIDTH, 32'd1));
        add_row(cfg_row(apam_pkg::CFG_DST_LINE, 32'd4));
        add_row(typed_row(0, 0, ORIGIN_OK));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (i = 0; i < dir_tab.size(); i++)
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
                drive_pixel(dir_tab[i].pix, 0, dir_tab[i].typed, dir_tab[i].want);
        end

        // random settings under three sender idle profiles
        for (ph = 0; ph < 3; ph++)
        begin
            for (s = 0; s < SETTINGS_PER_PHASE; s++)
            begin
                drain();
                pick_setting();
                for (k = 0; k < ITEMS_PER_SETTING; k++)
                    drive_pixel(rand_pixel(), pick_gap(idle_pct[ph]), 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d coordinate transfers, %0d results (%0d in range), %0d register writes",
                 n_in, n_out, n_valid, n_writes);
        $display("tb: all modes incl. unused codes, register extremes, three idle profiles");
        if (map_errors == 0 && pending_maps.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
